>>> sv/sal_pkg.sv
package sal_pkg;

	localparam int DEPTH = 64;
	localparam int DW = 32;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = IDX_W + 1;
	localparam int LANE_W = 3;
	localparam int GRP_W = IDX_W - LANE_W;
	localparam int NGRP = DEPTH / (1 << LANE_W);

	localparam logic [2:0] MODE_ADD_TAIL = 3'd0;
	localparam logic [2:0] MODE_ADD_HEAD = 3'd1;
	localparam logic [2:0] MODE_REM_AT = 3'd2;
	localparam logic [2:0] MODE_REM_HEAD = 3'd3;
	localparam logic [2:0] MODE_REM_TAIL = 3'd4;
	localparam logic [2:0] MODE_GET_AT = 3'd5;
	localparam logic [2:0] MODE_READ_NEXT = 3'd6;
	localparam logic [2:0] MODE_CLEAR = 3'd7;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_BAD = 2'd2;

	typedef struct packed {
		logic load;
		logic lookup;
		logic apply;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_busy;
	} dp_status_t;

endpackage

>>> sv/sal_req_if.sv
interface sal_req_if;
	logic valid;
	logic ready;
	logic [2:0] mode;
	logic [6:0] position;
	logic [31:0] value;

	modport source (output valid, output mode, output position, output value, input ready);
	modport sink (input valid, input mode, input position, input value, output ready);
endinterface

>>> sv/sal_rsp_if.sv
interface sal_rsp_if;
	logic valid;
	logic ready;
	logic [31:0] data_out;
	logic [6:0] next_position;
	logic [6:0] count;
	logic new_flag;
	logic [1:0] status;

	modport source (output valid, output data_out, output next_position, output count,
		output new_flag, output status, input ready);
	modport sink (input valid, input data_out, input next_position, input count,
		input new_flag, input status, output ready);
endinterface

>>> sv/sal_ctrl.sv
module sal_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  sal_pkg::dp_status_t   stat,
	output sal_pkg::ctrl_cmd_t    cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LOOK = 2'd1;
	localparam logic [1:0] S_APPLY = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		req_ready = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				cmd.lookup = 1'b1;
				state_d = S_APPLY;
			end
			S_APPLY: begin
				// wait until the result register can take the word
				if (!stat.out_busy) begin
					cmd.apply = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> sv/sal_datapath.sv
module sal_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sal_pkg::ctrl_cmd_t    cmd,
	output sal_pkg::dp_status_t   stat,
	input  logic [2:0]            mode,
	input  logic [6:0]            position,
	input  logic [31:0]           value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [31:0]           data_out,
	output logic [6:0]            next_position,
	output logic [6:0]            count,
	output logic                  new_flag,
	output logic [1:0]            status
);

	localparam int DEPTH = sal_pkg::DEPTH;
	localparam int DW = sal_pkg::DW;
	localparam int IDX_W = sal_pkg::IDX_W;
	localparam int CNT_W = sal_pkg::CNT_W;
	localparam int LANE_W = sal_pkg::LANE_W;
	localparam int GRP_W = sal_pkg::GRP_W;
	localparam int NGRP = sal_pkg::NGRP;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [DW-1:0] cells_q [DEPTH];
	logic [DW-1:0] shift_up [DEPTH];
	logic [DW-1:0] shift_dn [DEPTH];
	logic [CNT_W-1:0] count_q;
	logic flag_q;

	logic [2:0] mode_q;
	logic [CNT_W-1:0] pos_q;
	logic [DW-1:0] val_q;

	logic [IDX_W-1:0] idx_c;
	logic [1:0] st_c;
	logic [CNT_W-1:0] pos_m1;
	logic [CNT_W-1:0] cnt_m1;
	logic pos_bad;

	logic [DW-1:0] grp_s1 [NGRP];
	logic [IDX_W-1:0] idx_s1;
	logic [1:0] st_s1;

	logic [DW-1:0] rd_data;
	logic [CNT_W-1:0] pos_p1;
	logic ok;

	logic out_valid_q;
	logic [DW-1:0] data_q;
	logic [CNT_W-1:0] next_q;
	logic [1:0] status_q;

	// neighbor taps for the two shift directions
	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_tap
			if (gi == 0) begin : g_lo
				assign shift_up[gi] = val_q;
			end else begin : g_up
				assign shift_up[gi] = cells_q[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_hi
				assign shift_dn[gi] = '0;
			end else begin : g_dn
				assign shift_dn[gi] = cells_q[gi+1];
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			pos_q <= position;
			val_q <= value[DW-1:0];
		end
	end

	// range checks and the cell index that the operation reads
	always_comb begin
		pos_m1 = pos_q - CNT_W'(1);
		cnt_m1 = count_q - CNT_W'(1);
		pos_bad = (pos_q == '0) || (pos_q > count_q);
		idx_c = '0;
		st_c = sal_pkg::ST_OK;
		unique case (mode_q)
			sal_pkg::MODE_ADD_TAIL, sal_pkg::MODE_ADD_HEAD: begin
				if (count_q == FULL_CNT) st_c = sal_pkg::ST_FULL;
			end
			sal_pkg::MODE_REM_AT, sal_pkg::MODE_READ_NEXT: begin
				idx_c = pos_m1[IDX_W-1:0];
				if (pos_bad) st_c = sal_pkg::ST_BAD;
			end
			sal_pkg::MODE_REM_HEAD: begin
				if (count_q == '0) st_c = sal_pkg::ST_BAD;
			end
			sal_pkg::MODE_REM_TAIL: begin
				idx_c = cnt_m1[IDX_W-1:0];
				if (count_q == '0) st_c = sal_pkg::ST_BAD;
			end
			sal_pkg::MODE_GET_AT: begin
				idx_c = pos_q[IDX_W-1:0];
				if (pos_q >= count_q) st_c = sal_pkg::ST_BAD;
			end
			sal_pkg::MODE_CLEAR: begin
				st_c = sal_pkg::ST_OK;
			end
			default: begin
				st_c = sal_pkg::ST_OK;
			end
		endcase
	end

	// first level of the read mux: one lane per group of eight cells
	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			for (int g = 0; g < NGRP; g++) begin
				grp_s1[g] <= cells_q[{GRP_W'(g), idx_c[LANE_W-1:0]}];
			end
			idx_s1 <= idx_c;
			st_s1 <= st_c;
		end
	end

	assign rd_data = grp_s1[idx_s1[IDX_W-1:LANE_W]];
	assign ok = (st_s1 == sal_pkg::ST_OK);
	assign pos_p1 = pos_q + CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_q <= '{default: '0};
			count_q <= '0;
			flag_q <= 1'b0;
		end else if (cmd.apply && ok) begin
			unique case (mode_q)
				sal_pkg::MODE_ADD_TAIL: begin
					cells_q[count_q[IDX_W-1:0]] <= val_q;
					count_q <= count_q + CNT_W'(1);
					flag_q <= 1'b1;
				end
				sal_pkg::MODE_ADD_HEAD: begin
					// top cell is empty here, so shifting the whole row is safe
					for (int i = 0; i < DEPTH; i++) begin
						cells_q[i] <= shift_up[i];
					end
					count_q <= count_q + CNT_W'(1);
					flag_q <= 1'b1;
				end
				sal_pkg::MODE_REM_AT, sal_pkg::MODE_REM_HEAD, sal_pkg::MODE_REM_TAIL: begin
					// cells above the count hold zero, so the vacated cell clears itself
					for (int i = 0; i < DEPTH; i++) begin
						if (IDX_W'(i) >= idx_s1) cells_q[i] <= shift_dn[i];
					end
					count_q <= count_q - CNT_W'(1);
				end
				sal_pkg::MODE_GET_AT, sal_pkg::MODE_READ_NEXT: begin
					count_q <= count_q;
				end
				sal_pkg::MODE_CLEAR: begin
					flag_q <= 1'b0;
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.apply) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			status_q <= st_s1;
			data_q <= '0;
			next_q <= '0;
			if (ok && mode_q != sal_pkg::MODE_ADD_TAIL && mode_q != sal_pkg::MODE_ADD_HEAD
				&& mode_q != sal_pkg::MODE_CLEAR) begin
				data_q <= rd_data;
			end
			if (ok && mode_q == sal_pkg::MODE_READ_NEXT && pos_p1 <= count_q) begin
				next_q <= pos_p1;
			end
		end
	end

	assign stat.out_busy = out_valid_q && !out_ready;
	assign out_valid = out_valid_q;
	assign data_out = 32'(data_q);
	assign next_position = next_q;
	assign count = count_q;
	assign new_flag = flag_q;
	assign status = status_q;

endmodule

>>> sv/shifting_array_list.sv
// packed list of up to 64 32-bit words held in a row of shift cells; each request word
// carries one operation (append, prepend, remove at position, remove head or tail, get at
// index, iterator read, clear the new-data flag) and yields exactly one response word with
// the count after the operation, the new-data flag and a status. one request is handled at
// a time: the request is registered at the accepting edge, a lookup state registers the
// first level of the 64-to-1 read mux over the cells, and an apply state makes the final
// select together with the shift of the whole row and registers the response; the next
// request can be accepted while that response is valid. a stalled response holds the
// list: the next request is taken in and looked up but not applied until the response
// is taken.
module shifting_array_list (
	input  logic       clk,
	input  logic       arst_n,
	sal_req_if.sink    req,
	sal_rsp_if.source  rsp
);

	sal_pkg::ctrl_cmd_t cmd;
	sal_pkg::dp_status_t stat;

	sal_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sal_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.mode          (req.mode),
		.position      (req.position),
		.value         (req.value),
		.out_valid     (rsp.valid),
		.out_ready     (rsp.ready),
		.data_out      (rsp.data_out),
		.next_position (rsp.next_position),
		.count         (rsp.count),
		.new_flag      (rsp.new_flag),
		.status        (rsp.status)
	);

endmodule
